### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the RTL; each expects clk and rst_n
// in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/wsgc_pkg.sv
// ----------------------------------------------------------------------------
// wsgc_pkg
// Widths, codes and helpers of the window spread gesture classifier.
// ----------------------------------------------------------------------------
package wsgc_pkg;

  localparam int NUM_CH      = 3;
  localparam int IN_W        = 16;
  localparam int SUM_W       = 22;
  localparam int SQ_W        = 36;
  localparam int SSQ_W       = 2 * SUM_W;
  localparam int PROD_W      = 48;
  localparam int SPREAD_W    = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int WINDOW_DEF  = 32;
  localparam int IN_TDATA_W  = NUM_CH * IN_W;
  localparam int OUT_TDATA_W = NUM_CH * SPREAD_W;
  localparam int OUT_TUSER_W = 2;

  // channel slots, in tdata order
  localparam int CH_ACCEL = 0;
  localparam int CH_ROLL  = 1;
  localparam int CH_YAW   = 2;

  typedef enum logic [OUT_TUSER_W-1:0] {
    SYM_DOT   = 2'd0,
    SYM_DASH  = 2'd1,
    SYM_SPACE = 2'd2
  } symbol_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOT_ACCEL_LOW  = 3'd0,
    REG_DOT_ACCEL_HIGH = 3'd1,
    REG_DOT_YAW_LOW    = 3'd2,
    REG_DOT_YAW_HIGH   = 3'd3,
    REG_DASH_ROLL_LOW  = 3'd4,
    REG_DASH_ROLL_HIGH = 3'd5
  } cfg_reg_t;

  typedef logic [SPREAD_W-1:0] spread_t;

  // inclusive band; empty when low > high
  function automatic logic in_band(input spread_t v, input spread_t lo, input spread_t hi);
    in_band = (v >= lo) && (v <= hi);
  endfunction

endpackage

### src/window_spread_gesture_classifier.sv
// ----------------------------------------------------------------------------
// window_spread_gesture_classifier
// Per-window spread of three motion channels and a dot/dash/space decision.
//
//   channel  dir  handshake           payload
//   in_      in   tvalid/tready       tdata: accel_y, gyro_x, gyro_z
//   out_     out  tvalid/tready       tdata: spreads; tuser: symbol
//   cfg_     in   valid/ready         index, data (band limits)
//
// One sample per cycle while in_tready is high; the last sample of a window
// goes from the input register through the square, accumulate, product,
// spread and compare stages to its result. Reset is synchronous and clears
// accumulators, band limits and all valid flags. A waiting result sits in
// the output register while samples keep accumulating; input stalls only
// once three more finished windows back up in the window, product and
// spread stages and a fourth one completes before that result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module window_spread_gesture_classifier #(
  parameter int WINDOW = wsgc_pkg::WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wsgc_pkg::IN_TDATA_W-1:0]    in_tdata,   // accel_y, gyro_x, gyro_z
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wsgc_pkg::OUT_TDATA_W-1:0]   out_tdata,  // accel, roll, yaw spread
  output logic [wsgc_pkg::OUT_TUSER_W-1:0]   out_tuser,  // symbol
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wsgc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wsgc_pkg::SPREAD_W-1:0]      cfg_data
);

  import wsgc_pkg::*;

  localparam int CNT_W = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WINDOW - 1);

  // band limits
  spread_t dot_accel_low_r, dot_accel_high_r;
  spread_t dot_yaw_low_r, dot_yaw_high_r;
  spread_t dash_roll_low_r, dash_roll_high_r;

  // input register
  logic                    v0_r;
  logic signed [IN_W-1:0]  x0_r [NUM_CH];
  // square stage
  logic                    v1_r;
  logic signed [IN_W-1:0]  x1_r [NUM_CH];
  logic [2*IN_W-1:0]       xsq1_r [NUM_CH];
  logic signed [2*IN_W-1:0] xsq0 [NUM_CH];
  // accumulators
  logic [CNT_W-1:0]        cnt_r;
  logic signed [SUM_W-1:0] sum_r [NUM_CH];
  logic [SQ_W-1:0]         sq_r [NUM_CH];
  logic signed [SUM_W-1:0] sum_nxt [NUM_CH];
  logic [SQ_W-1:0]         sq_nxt [NUM_CH];
  // window totals
  logic                    vw_r;
  logic signed [SUM_W-1:0] wsum_r [NUM_CH];
  logic [SQ_W-1:0]         wsq_r [NUM_CH];
  // products
  logic                    vp_r;
  logic [SSQ_W-1:0]        ssq_r [NUM_CH];
  logic [PROD_W-1:0]       wprod_r [NUM_CH];
  logic signed [SSQ_W-1:0] ssq_c [NUM_CH];
  // spread
  logic                    vs_r;
  spread_t                 spread_r [NUM_CH];
  spread_t                 spread_nxt [NUM_CH];
  logic [PROD_W:0]         diff [NUM_CH];
  // output register
  logic                    out_valid_r;
  symbol_t                 sym_r;
  symbol_t                 sym_nxt;
  spread_t                 out_spread_r [NUM_CH];

  logic go0, go1, go_w, go_p, go_s, last1;
  logic window_cleared, spreads_nonneg, dot_accel_in_band;

  assign go_s  = vs_r && (!out_valid_r || out_tready);
  assign go_p  = vp_r && (!vs_r || go_s);
  assign go_w  = vw_r && (!vp_r || go_p);
  assign last1 = (cnt_r == LAST_CNT);
  assign go1   = v1_r && (!last1 || !vw_r || go_w);
  assign go0   = v0_r && (!v1_r || go1);

  assign in_tready  = !v0_r || go0;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = sym_r;
  assign out_tdata  = {out_spread_r[CH_YAW], out_spread_r[CH_ROLL], out_spread_r[CH_ACCEL]};

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      xsq0[c]    = x0_r[c] * x0_r[c];
      sum_nxt[c] = sum_r[c] + SUM_W'(x1_r[c]);
      sq_nxt[c]  = sq_r[c] + SQ_W'(xsq1_r[c]);
      ssq_c[c]   = wsum_r[c] * wsum_r[c];
      diff[c]    = {1'b0, wprod_r[c]} - {1'b0, PROD_W'(ssq_r[c])};
      spread_nxt[c] = diff[c][PROD_W] ? '0 : diff[c][SPREAD_W-1:0];
    end
  end

  always_comb begin
    if (in_band(spread_r[CH_ACCEL], dot_accel_low_r, dot_accel_high_r) &&
        in_band(spread_r[CH_YAW], dot_yaw_low_r, dot_yaw_high_r)) begin
      sym_nxt = SYM_DOT;
    end else if (in_band(spread_r[CH_ROLL], dash_roll_low_r, dash_roll_high_r)) begin
      sym_nxt = SYM_DASH;
    end else begin
      sym_nxt = SYM_SPACE;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_accel_low_r  <= '0;
      dot_accel_high_r <= '0;
      dot_yaw_low_r    <= '0;
      dot_yaw_high_r   <= '0;
      dash_roll_low_r  <= '0;
      dash_roll_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_DOT_ACCEL_LOW:  dot_accel_low_r  <= cfg_data;
        REG_DOT_ACCEL_HIGH: dot_accel_high_r <= cfg_data;
        REG_DOT_YAW_LOW:    dot_yaw_low_r    <= cfg_data;
        REG_DOT_YAW_HIGH:   dot_yaw_high_r   <= cfg_data;
        REG_DASH_ROLL_LOW:  dash_roll_low_r  <= cfg_data;
        REG_DASH_ROLL_HIGH: dash_roll_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid flags and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      vw_r        <= 1'b0;
      vp_r        <= 1'b0;
      vs_r        <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        sum_r[c] <= '0;
        sq_r[c]  <= '0;
      end
    end else begin
      if (in_tready)  v0_r <= in_tvalid;
      if (!v1_r || go1) v1_r <= go0;
      if (!vw_r || go_w) vw_r <= go1 && last1;
      if (!vp_r || go_p) vp_r <= go_w;
      if (!vs_r || go_s) vs_r <= go_p;
      if (!out_valid_r || out_tready) out_valid_r <= go_s;
      if (go1) begin
        cnt_r <= last1 ? '0 : cnt_r + CNT_W'(1);
        for (int c = 0; c < NUM_CH; c++) begin
          sum_r[c] <= last1 ? '0 : sum_nxt[c];
          sq_r[c]  <= last1 ? '0 : sq_nxt[c];
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      for (int c = 0; c < NUM_CH; c++) begin
        x0_r[c] <= in_tdata[c*IN_W +: IN_W];
      end
    end
    if (go0) begin
      for (int c = 0; c < NUM_CH; c++) begin
        x1_r[c]   <= x0_r[c];
        xsq1_r[c] <= unsigned'(xsq0[c]);
      end
    end
    if (go1 && last1) begin
      for (int c = 0; c < NUM_CH; c++) begin
        wsum_r[c] <= sum_nxt[c];
        wsq_r[c]  <= sq_nxt[c];
      end
    end
    if (go_w) begin
      for (int c = 0; c < NUM_CH; c++) begin
        ssq_r[c]   <= unsigned'(ssq_c[c]);
        wprod_r[c] <= PROD_W'(wsq_r[c]) * PROD_W'(WINDOW);
      end
    end
    if (go_p) begin
      for (int c = 0; c < NUM_CH; c++) begin
        spread_r[c] <= spread_nxt[c];
      end
    end
    if (go_s) begin
      sym_r <= sym_nxt;
      for (int c = 0; c < NUM_CH; c++) begin
        out_spread_r[c] <= spread_r[c];
      end
    end
  end

  assign window_cleared = (cnt_r == '0) && (sum_r[CH_ACCEL] == '0) && (sq_r[CH_YAW] == '0);
  assign spreads_nonneg = (PROD_W'(ssq_r[CH_ACCEL]) <= wprod_r[CH_ACCEL]) &&
                          (PROD_W'(ssq_r[CH_ROLL]) <= wprod_r[CH_ROLL]) &&
                          (PROD_W'(ssq_r[CH_YAW]) <= wprod_r[CH_YAW]);
  assign dot_accel_in_band = in_band(out_spread_r[CH_ACCEL], dot_accel_low_r, dot_accel_high_r);

  `ASSERT_ALWAYS(a_cnt_range, cnt_r <= LAST_CNT, "sample count passed the window")
  `ASSERT_NEXT(a_window_clear, go1 && last1, window_cleared, "accumulators not cleared")
  `ASSERT_IMPLY(a_spread_nonneg, vp_r, spreads_nonneg, "negative spread")
  `ASSERT_IMPLY(a_dot_band, out_valid_r && sym_r == SYM_DOT, dot_accel_in_band, "dot outside band")

endmodule

### tb/sv/tb_window_spread_gesture_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_spread_gesture_classifier
// Streams windows of motion samples into the classifier and checks each
// symbol and the three scaled spreads against a table row or an in-bench
// predictor. A short alternating-value table leads, then randomly shaped
// windows under changing band limits, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_window_spread_gesture_classifier;
  import wsgc_pkg::*;

  localparam int WIN               = WINDOW_DEF;
  localparam int DRAIN_CYCLES      = 20;
  localparam int SETTLE_GUARD      = 4000;
  localparam int RANDOM_WINDOWS    = 28;
  localparam int WINDOWS_PER_PHASE = 4;
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_HI = 3'd7;
  localparam spread_t SPREAD_MAX        = {SPREAD_W{1'b1}};
  localparam spread_t FULL_SWING_SPREAD = 40'd1099478073600;

  typedef enum {SPAN_FULL, SPAN_RAIL, SPAN_FLAT, SPAN_NOISE} swing_t;

  typedef struct packed {
    logic signed [IN_W-1:0] gyro_z;
    logic signed [IN_W-1:0] gyro_x;
    logic signed [IN_W-1:0] accel_y;
  } motion_t;

  typedef struct packed {
    symbol_t sym;
    spread_t accel;
    spread_t roll;
    spread_t yaw;
  } verdict_t;

  typedef struct {
    logic signed [IN_W-1:0] accel_even, accel_odd;
    logic signed [IN_W-1:0] roll_even, roll_odd;
    logic signed [IN_W-1:0] yaw_even, yaw_odd;
    bit                     typed;
    verdict_t               want;
  } pattern_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [SPREAD_W-1:0]    cfg_data   = '0;

  spread_t  band_limit [6] = '{default: '0};
  longint   chan_sum [NUM_CH] = '{default: 0};
  longint   chan_sq [NUM_CH]  = '{default: 0};
  int       fill      = 0;
  verdict_t pending_verdicts [$];
  pattern_t patterns [$];
  int       err_count = 0;
  bit       tx_calm   = 1'b1;
  bit       rx_calm   = 1'b1;
  int       rx_stall  = 0;

  window_spread_gesture_classifier #(.WINDOW(WIN)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic flag_error(input string what, input logic [SPREAD_W-1:0] want,
                            input logic [SPREAD_W-1:0] got);
    $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    err_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic spread_t spread_of(input longint s, input longint sq);
    longint d;
    d = WIN * sq - s * s;
    if (d < 0) d = 0;
    return d[SPREAD_W-1:0];
  endfunction

  function automatic bit accumulate_sample(input motion_t m, output verdict_t v);
    longint x [NUM_CH];
    bit     dot_ok;
    v = '0;
    x[CH_ACCEL] = longint'($signed(m.accel_y));
    x[CH_ROLL]  = longint'($signed(m.gyro_x));
    x[CH_YAW]   = longint'($signed(m.gyro_z));
    for (int c = 0; c < NUM_CH; c++) begin
      chan_sum[c] += x[c];
      chan_sq[c]  += x[c] * x[c];
    end
    fill++;
    if (fill < WIN) return 1'b0;
    v.accel = spread_of(chan_sum[CH_ACCEL], chan_sq[CH_ACCEL]);
    v.roll  = spread_of(chan_sum[CH_ROLL], chan_sq[CH_ROLL]);
    v.yaw   = spread_of(chan_sum[CH_YAW], chan_sq[CH_YAW]);
    dot_ok = v.accel >= band_limit[REG_DOT_ACCEL_LOW] && v.accel <= band_limit[REG_DOT_ACCEL_HIGH]
          && v.yaw >= band_limit[REG_DOT_YAW_LOW] && v.yaw <= band_limit[REG_DOT_YAW_HIGH];
    if (dot_ok)
      v.sym = SYM_DOT;
    else if (v.roll >= band_limit[REG_DASH_ROLL_LOW] && v.roll <= band_limit[REG_DASH_ROLL_HIGH])
      v.sym = SYM_DASH;
    else
      v.sym = SYM_SPACE;
    fill = 0;
    for (int c = 0; c < NUM_CH; c++) begin
      chan_sum[c] = 0;
      chan_sq[c]  = 0;
    end
    return 1'b1;
  endfunction

  task automatic send_motion(input motion_t m, input bit typed, input verdict_t want);
    int       gap;
    verdict_t v;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= m;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (accumulate_sample(m, v)) pending_verdicts.push_back(typed ? want : v);
  endtask

  // wait for every owed result, then let the pipeline empty
  task automatic settle();
    int guard;
    guard = 0;
    while (pending_verdicts.size() != 0 && guard < SETTLE_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (pending_verdicts.size() != 0) begin
      flag_error("results never delivered", 0, pending_verdicts.size());
      pending_verdicts.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input spread_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx <= REG_DASH_ROLL_HIGH) band_limit[idx] = value;
  endtask

  task automatic program_bands(input spread_t al, input spread_t ah, input spread_t yl,
                               input spread_t yh, input spread_t rl, input spread_t rh);
    settle();
    write_reg(REG_DOT_ACCEL_LOW, al);
    write_reg(REG_DOT_ACCEL_HIGH, ah);
    write_reg(REG_DOT_YAW_LOW, yl);
    write_reg(REG_DOT_YAW_HIGH, yh);
    write_reg(REG_DASH_ROLL_LOW, rl);
    write_reg(REG_DASH_ROLL_HIGH, rh);
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? SPARE_INDEX_HI : SPARE_INDEX_LO,
                SPREAD_W'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  function automatic spread_t band_edge(input int sigma);
    longint w;
    w = longint'(WIN) * sigma;
    return SPREAD_W'(w * w);
  endfunction

  task automatic program_random_bands();
    spread_t lim [6];
    int      mode;
    int      lo_s;
    int      hi_s;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 6; k += 2) begin
      lo_s = $urandom_range(0, 1200);
      hi_s = lo_s + $urandom_range(0, 1500);
      if ($urandom_range(0, 9) == 0) lo_s = hi_s + $urandom_range(1, 500);
      lim[k]     = band_edge(lo_s);
      lim[k + 1] = band_edge(hi_s);
      if (mode == 0) begin
        lim[k]     = '0;
        lim[k + 1] = SPREAD_MAX;
      end else if (mode == 1) begin
        lim[k]     = '0;
        lim[k + 1] = '0;
      end
    end
    program_bands(lim[0], lim[1], lim[2], lim[3], lim[4], lim[5]);
  endtask

  function automatic logic signed [IN_W-1:0] draw_value(input swing_t swing, input int center,
                                                        input int amp);
    int v;
    case (swing)
      SPAN_FULL: v = int'($urandom_range(0, 65535)) - 32768;
      SPAN_RAIL: v = $urandom_range(0, 1) ? 32767 : -32768;
      SPAN_FLAT: v = center;
      default:   v = center + int'($urandom_range(0, 2 * amp)) - amp;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[IN_W-1:0];
  endfunction

  task automatic send_random_samples(input int count);
    swing_t                 swing [NUM_CH];
    int                     center [NUM_CH];
    int                     amp [NUM_CH];
    logic signed [IN_W-1:0] val [NUM_CH];
    int                     r;
    motion_t                m;
    for (int c = 0; c < NUM_CH; c++) begin
      r = $urandom_range(0, 9);
      swing[c]  = (r == 0) ? SPAN_FULL : (r == 1) ? SPAN_RAIL : (r < 4) ? SPAN_FLAT : SPAN_NOISE;
      center[c] = int'($urandom_range(0, 40000)) - 20000;
      amp[c]    = 3 * (7 ** int'($urandom_range(0, 4)));
    end
    for (int i = 0; i < count; i++) begin
      for (int c = 0; c < NUM_CH; c++) val[c] = draw_value(swing[c], center[c], amp[c]);
      m.accel_y = val[CH_ACCEL];
      m.gyro_x  = val[CH_ROLL];
      m.gyro_z  = val[CH_YAW];
      send_motion(m, 1'b0, '0);
    end
  endtask

  function automatic void add_pattern(input int ae, input int ao, input int re, input int ro,
                                      input int ye, input int yo, input bit typed,
                                      input symbol_t sym, input spread_t sa,
                                      input spread_t sr, input spread_t sy);
    pattern_t p;
    p.accel_even = ae[IN_W-1:0];
    p.accel_odd  = ao[IN_W-1:0];
    p.roll_even  = re[IN_W-1:0];
    p.roll_odd   = ro[IN_W-1:0];
    p.yaw_even   = ye[IN_W-1:0];
    p.yaw_odd    = yo[IN_W-1:0];
    p.typed      = typed;
    p.want.sym   = sym;
    p.want.accel = sa;
    p.want.roll  = sr;
    p.want.yaw   = sy;
    patterns.push_back(p);
  endfunction

  // alternating windows: spread = 256 * (even - odd)^2; all bands still at zero
  task automatic run_pattern_table();
    motion_t m;
    add_pattern(0, 0, 0, 0, 0, 0, 1, SYM_DOT, 0, 0, 0);
    add_pattern(32767, 32767, 32767, 32767, 32767, 32767, 1, SYM_DOT, 0, 0, 0);
    add_pattern(-32768, -32768, -32768, -32768, -32768, -32768, 1, SYM_DOT, 0, 0, 0);
    add_pattern(32767, -32768, 0, 0, 0, 0, 1, SYM_DASH, FULL_SWING_SPREAD, 0, 0);
    add_pattern(0, 0, 0, 0, 1, -1, 1, SYM_DASH, 0, 0, 40'd1024);
    add_pattern(0, 0, -32768, 32767, 0, 0, 1, SYM_DOT, 0, FULL_SWING_SPREAD, 0);
    add_pattern(32767, -32768, -32768, 32767, 32767, -32768, 1, SYM_SPACE,
                FULL_SWING_SPREAD, FULL_SWING_SPREAD, FULL_SWING_SPREAD);
    add_pattern(100, -100, 5, 6, -7, -7, 1, SYM_SPACE, 40'd10240000, 40'd256, 0);
    add_pattern(1234, -4321, 21845, -21846, -1, 0, 0, SYM_DOT, 0, 0, 0);
    add_pattern(16384, -16385, 0, -1, 12345, -23456, 0, SYM_DOT, 0, 0, 0);
    foreach (patterns[p]) begin
      tx_calm = ($urandom_range(0, 2) == 0);
      rx_calm = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < WIN; i++) begin
        m.accel_y = (i % 2 == 0) ? patterns[p].accel_even : patterns[p].accel_odd;
        m.gyro_x  = (i % 2 == 0) ? patterns[p].roll_even : patterns[p].roll_odd;
        m.gyro_z  = (i % 2 == 0) ? patterns[p].yaw_even : patterns[p].yaw_odd;
        send_motion(m, patterns[p].typed, patterns[p].want);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall   <= rx_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if (!rx_calm) rx_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin : watch_results
    verdict_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        flag_error("result with no window pending", 0, 1);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tuser !== want.sym) flag_error("symbol", want.sym, out_tuser);
        if (out_tdata[CH_ACCEL*SPREAD_W +: SPREAD_W] !== want.accel)
          flag_error("accel spread", want.accel, out_tdata[CH_ACCEL*SPREAD_W +: SPREAD_W]);
        if (out_tdata[CH_ROLL*SPREAD_W +: SPREAD_W] !== want.roll)
          flag_error("roll spread", want.roll, out_tdata[CH_ROLL*SPREAD_W +: SPREAD_W]);
        if (out_tdata[CH_YAW*SPREAD_W +: SPREAD_W] !== want.yaw)
          flag_error("yaw spread", want.yaw, out_tdata[CH_YAW*SPREAD_W +: SPREAD_W]);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unused indexes must leave the zero bands untouched
    write_reg(SPARE_INDEX_LO, SPREAD_MAX);
    write_reg(SPARE_INDEX_HI, SPREAD_MAX);
    cfg_valid <= 1'b0;
    run_pattern_table();

    program_bands('0, SPREAD_MAX, '0, SPREAD_MAX, '0, SPREAD_MAX);
    send_random_samples(WIN);
    send_random_samples(WIN);
    in_tvalid <= 1'b0;

    program_bands(SPREAD_MAX, '0, SPREAD_MAX, '0, SPREAD_MAX, '0);
    send_random_samples(WIN);
    send_random_samples(WIN);
    in_tvalid <= 1'b0;

    for (int ph = 0; ph < RANDOM_WINDOWS / WINDOWS_PER_PHASE; ph++) begin
      program_random_bands();
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      repeat (WINDOWS_PER_PHASE) send_random_samples(WIN);
      in_tvalid <= 1'b0;
    end

    // leave a partial window behind
    send_random_samples($urandom_range(1, WIN - 1));
    in_tvalid <= 1'b0;
    settle();

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/wsgc_pkg.sv
src/window_spread_gesture_classifier.sv
tb/sv/tb_window_spread_gesture_classifier.sv
